>>> hw/rtl/bbp_pkg.sv
`default_nettype none

package bbp_pkg;

  localparam int PC_W      = 32;
  localparam int COUNT_W   = 32;
  localparam int CFG_W     = 4;
  localparam int DIR_W     = 2;
  // Widest index the address can supply: bits [17:2] of the PC.
  localparam int RAW_IDX_W = 16;
  localparam int PC_LSB    = 2;

  localparam logic [CFG_W-1:0] INDEX_BITS_RST = 4'd10;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam logic [DIR_W-1:0] DIR_STRONG_NT = 2'd0;
  localparam logic [DIR_W-1:0] DIR_WEAK_NT   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_WEAK_T    = 2'd2;
  localparam logic [DIR_W-1:0] DIR_STRONG_T  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_READ,
    ST_WRITE
  } seq_state_t;

  // Hysteresis transitions of a two-bit direction state.
  function automatic logic [DIR_W-1:0] next_dir(input logic [DIR_W-1:0] s,
                                                input logic taken);
    logic [DIR_W-1:0] n;
    n = DIR_STRONG_NT;
    case (s)
      DIR_STRONG_NT: n = taken ? DIR_WEAK_NT   : DIR_STRONG_NT;
      DIR_WEAK_NT:   n = taken ? DIR_STRONG_T  : DIR_STRONG_NT;
      DIR_WEAK_T:    n = taken ? DIR_STRONG_T  : DIR_STRONG_NT;
      DIR_STRONG_T:  n = taken ? DIR_STRONG_T  : DIR_WEAK_T;
      default:       n = DIR_STRONG_NT;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bbp_ram.sv
`default_nettype none

module bbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic [AW-1:0]          raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/bbp_index.sv
`default_nettype none

// Two-stage index reduction: mask the PC bits to the configured width, then
// fold the result into the table depth.
module bbp_index #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int IDX_W         = 10
) (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic [bbp_pkg::PC_W-1:0]   pc,
  input  wire logic [bbp_pkg::CFG_W-1:0]  index_bits,
  output logic      [IDX_W-1:0]           idx
);

  localparam int RW = bbp_pkg::RAW_IDX_W;
  localparam bit POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  logic [RW-1:0]    mask;
  logic [RW-1:0]    v_nxt;
  logic [RW-1:0]    v_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [IDX_W-1:0] idx_r;

  assign mask  = ~({RW{1'b1}} << index_bits);
  assign v_nxt = pc[bbp_pkg::PC_LSB +: RW] & mask;

  always_ff @(posedge clk) begin
    if (load) begin
      v_r <= v_nxt;
    end
  end

  generate
    if (POW2) begin : g_pow2
      localparam logic [RW-1:0] TMASK = RW'(TABLE_ENTRIES - 1);
      assign idx_nxt = IDX_W'(v_r & TMASK);
    end else begin : g_recip
      // Quotient by a rounded-up reciprocal; exact for 16-bit dividends.
      localparam longint MAGIC_L = ((64'd1 << 32) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
      localparam logic [31:0] MAGIC = 32'(MAGIC_L);
      localparam logic [RW:0] TDIV  = (RW + 1)'(TABLE_ENTRIES);
      logic [RW+31:0]   prod_r;
      logic [RW-1:0]    quot;
      logic [2*RW:0]    back;
      logic [2*RW:0]    rem;

      always_ff @(posedge clk) begin
        if (load) begin
          prod_r <= (RW + 32)'(v_nxt) * (RW + 32)'(MAGIC);
        end
      end

      assign quot    = prod_r[RW+31:32];
      assign back    = (2 * RW + 1)'(quot) * (2 * RW + 1)'(TDIV);
      assign rem     = (2 * RW + 1)'(v_r) - back;
      assign idx_nxt = IDX_W'(rem);
    end
  endgenerate

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign idx = idx_r;

endmodule

`default_nettype wire

>>> hw/rtl/bimodal_branch_predictor_unit.sv
`default_nettype none

// An accepted item goes through the index fold, the table read and the write
// back; its result then shows on the out_ ports, with out_valid high.
// Items are taken one at a time: busy stays high through the read-modify-write
// of the single direction table (index fold, memory read, write back) per item.
// Reset: synchronous on rst_n low; afterwards busy stays high for a clearing
// pass that zeroes every table entry. The receiver cannot stall.
module bimodal_branch_predictor_unit #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Item channel.
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_kind,
  input  wire logic [bbp_pkg::PC_W-1:0]      in_pc,
  input  wire logic                          in_outcome,
  // Result channel.
  output logic                               out_valid,
  output logic                               out_prediction,
  output logic [bbp_pkg::COUNT_W-1:0]        out_access_count,
  output logic [bbp_pkg::COUNT_W-1:0]        out_mispredict_count,
  // Configuration channel: the index width register.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bbp_pkg::CFG_W-1:0]     cfg_index_bits
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_ENTRIES - 1);
  localparam int CW = bbp_pkg::COUNT_W;
  localparam int DW = bbp_pkg::DIR_W;

  bbp_pkg::seq_state_t state_r, state_nxt;

  logic [IDX_W-1:0]          clr_addr_r, clr_addr_nxt;
  logic [bbp_pkg::CFG_W-1:0] index_bits_r;
  logic [CW-1:0]             acc_r, acc_nxt;
  logic [CW-1:0]             misp_r, misp_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      pred_r, pred_nxt;
  logic                      kind_r;
  logic                      outcome_r;

  logic                      accept;
  logic [IDX_W-1:0]          idx;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [DW-1:0]             ram_wdata;
  logic [DW-1:0]             ram_rdata;
  logic                      old_pred;

  assign busy      = (state_r != bbp_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // The index width register. Writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r <= bbp_pkg::INDEX_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      index_bits_r <= cfg_index_bits;
    end
  end

  // The index unit takes the PC straight from the ports at the accepting edge,
  // registers the masked value, and then registers the folded table index.
  bbp_index #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_index (
    .clk        (clk),
    .load       (accept),
    .pc         (in_pc),
    .index_bits (index_bits_r),
    .idx        (idx)
  );

  // The direction table. It is read every cycle at the current index; the data
  // used is the word read during the READ state. Only one item is in flight,
  // so a write back always lands before the next item's read.
  bbp_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // States 2 and 3 predict taken, so the upper bit is the prediction.
  assign old_pred = ram_rdata[DW-1];

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    acc_nxt       = acc_r;
    misp_nxt      = misp_r;
    out_valid_nxt = 1'b0;
    pred_nxt      = pred_r;
    ram_we        = 1'b0;
    ram_waddr     = idx;
    ram_wdata     = bbp_pkg::next_dir(ram_rdata, outcome_r);
    case (state_r)
      bbp_pkg::ST_CLEAR: begin
        // Sweep the table once after reset, one entry per cycle.
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = bbp_pkg::DIR_STRONG_NT;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = bbp_pkg::ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + IDX_W'(1);
        end
      end
      bbp_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = bbp_pkg::ST_INDEX;
        end
      end
      bbp_pkg::ST_INDEX: begin
        state_nxt = bbp_pkg::ST_READ;
      end
      bbp_pkg::ST_READ: begin
        state_nxt = bbp_pkg::ST_WRITE;
      end
      bbp_pkg::ST_WRITE: begin
        // The prediction always comes from the state before the update.
        out_valid_nxt = 1'b1;
        pred_nxt      = old_pred;
        if (kind_r == bbp_pkg::KIND_UPDATE) begin
          ram_we = 1'b1;
          if (acc_r != {CW{1'b1}}) begin
            acc_nxt = acc_r + CW'(1);
          end
          if ((old_pred != outcome_r) && (misp_r != {CW{1'b1}})) begin
            misp_nxt = misp_r + CW'(1);
          end
        end
        state_nxt = bbp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbp_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      acc_r       <= '0;
      misp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      acc_r       <= acc_nxt;
      misp_r      <= misp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pred_r <= pred_nxt;
    if (accept) begin
      kind_r    <= in_kind;
      outcome_r <= in_outcome;
    end
  end

  // The counters change at the same edge that raises the strobe, so they
  // read out directly.
  assign out_valid            = out_valid_r;
  assign out_prediction       = pred_r;
  assign out_access_count     = acc_r;
  assign out_mispredict_count = misp_r;

  // A result is shown for one cycle only.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // An accepted item always starts the index fold next.
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == bbp_pkg::ST_INDEX))
    else $error("accepted item did not enter the index stage");

  // Mispredictions are a subset of updates.
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    misp_r <= acc_r)
    else $error("mispredict count exceeds access count");

  // A lookup leaves both counters untouched.
  a_lookup_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == bbp_pkg::KIND_LOOKUP)) |-> ($stable(acc_r) && $stable(misp_r)))
    else $error("lookup changed a counter");

  // No result is produced while the table is being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bbp_pkg::ST_CLEAR) |=> !out_valid_r)
    else $error("result produced during the clearing pass");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the two-bit bimodal branch predictor.
// A local copy of the direction table and of the two saturating counters
// predicts every result. Items go in through the start/busy handshake, and
// each result strobe is checked against the oldest pending prediction.
module tb_top;

  localparam int          TABLE_ENTRIES = 1024;
  localparam int unsigned CYCLE_LIMIT   = 500_000;
  // Idle margin kept after the last pending result has been checked, so the
  // pipeline is quiet before the next step.
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOT_PCS       = 6;

  typedef struct packed {
    logic                        prediction;
    logic [bbp_pkg::COUNT_W-1:0] access_count;
    logic [bbp_pkg::COUNT_W-1:0] mispredict_count;
  } branch_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_kind;
  logic [bbp_pkg::PC_W-1:0]    in_pc;
  logic                        in_outcome;
  logic                        out_valid;
  logic                        out_prediction;
  logic [bbp_pkg::COUNT_W-1:0] out_access_count;
  logic [bbp_pkg::COUNT_W-1:0] out_mispredict_count;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [bbp_pkg::CFG_W-1:0]   cfg_index_bits;

  // Shadow state of the predictor.
  logic [bbp_pkg::DIR_W-1:0]   shadow_dirs [TABLE_ENTRIES];
  logic [bbp_pkg::COUNT_W-1:0] shadow_updates;
  logic [bbp_pkg::COUNT_W-1:0] shadow_wrong;
  logic [bbp_pkg::CFG_W-1:0]   shadow_width;

  // Predicted results, oldest first.
  branch_result_t     pending_results [$];
  int unsigned        error_count;
  int unsigned        cycle_count;

  bimodal_branch_predictor_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_pc               (in_pc),
    .in_outcome          (in_outcome),
    .out_valid           (out_valid),
    .out_prediction      (out_prediction),
    .out_access_count    (out_access_count),
    .out_mispredict_count(out_mispredict_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index_bits      (cfg_index_bits)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Table slot that a branch address selects under the current width. Widths
  // above 16 are clamped, and the masked index wraps around the table size.
  function automatic int unsigned slot_of(input logic [bbp_pkg::PC_W-1:0] pc);
    int unsigned width;
    logic [bbp_pkg::PC_W-1:0] mask;
    width = (shadow_width > bbp_pkg::RAW_IDX_W) ? bbp_pkg::RAW_IDX_W : shadow_width;
    mask  = (32'd1 << width) - 32'd1;
    return ((pc >> bbp_pkg::PC_LSB) & mask) % TABLE_ENTRIES;
  endfunction

  // Hysteresis: a single wrong outcome moves a strong state to the weak one
  // on its side, while a weak state falls back to strongly not taken on a
  // not-taken outcome and jumps to strongly taken on a taken one.
  function automatic logic [bbp_pkg::DIR_W-1:0] step_dir(
      input logic [bbp_pkg::DIR_W-1:0] s, input logic taken);
    logic [bbp_pkg::DIR_W-1:0] n;
    n = bbp_pkg::DIR_STRONG_NT;
    if (taken) begin
      if (s == bbp_pkg::DIR_STRONG_NT) n = bbp_pkg::DIR_WEAK_NT;
      else n = bbp_pkg::DIR_STRONG_T;
    end else begin
      if (s == bbp_pkg::DIR_STRONG_T) n = bbp_pkg::DIR_WEAK_T;
      else n = bbp_pkg::DIR_STRONG_NT;
    end
    return n;
  endfunction

  // Applies one accepted item to the shadow state and queues its result.
  task automatic resolve_branch(input logic kind, input logic [bbp_pkg::PC_W-1:0] pc,
                                input logic outcome);
    int unsigned               slot;
    logic [bbp_pkg::DIR_W-1:0] old_dir;
    branch_result_t            res;
    slot    = slot_of(pc);
    old_dir = shadow_dirs[slot];
    res.prediction = (old_dir == bbp_pkg::DIR_WEAK_T) ||
                     (old_dir == bbp_pkg::DIR_STRONG_T);
    if (kind == bbp_pkg::KIND_UPDATE) begin
      if (shadow_updates != '1) shadow_updates = shadow_updates + 1'b1;
      if (res.prediction != outcome && shadow_wrong != '1)
        shadow_wrong = shadow_wrong + 1'b1;
      shadow_dirs[slot] = step_dir(old_dir, outcome);
    end
    res.access_count     = shadow_updates;
    res.mispredict_count = shadow_wrong;
    pending_results.push_back(res);
  endtask

  // Sends one item after an idle gap of the given number of cycles. The task
  // is entered and left just after a falling edge. start stays high on exit,
  // so a following item with no gap goes out back to back.
  task automatic send_item(input logic kind, input logic [bbp_pkg::PC_W-1:0] pc,
                           input logic outcome, input int unsigned gap);
    if (gap != 0) begin
      start      = 1'b0;
      // The payload is junk while start is low and must be ignored.
      in_kind    = 1'($urandom);
      in_pc      = $urandom;
      in_outcome = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    in_kind    = kind;
    in_pc      = pc;
    in_outcome = outcome;
    do @(posedge clk); while (busy !== 1'b0);
    resolve_branch(kind, pc, outcome);
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted result has been checked.
  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the index width once the block has gone idle.
  task automatic write_index_bits(input logic [bbp_pkg::CFG_W-1:0] width);
    drain_results();
    cfg_valid      = 1'b1;
    cfg_index_bits = width;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    shadow_width = width;
    @(negedge clk);
    cfg_valid      = 1'b0;
    cfg_index_bits = bbp_pkg::CFG_W'($urandom);
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Right after reset the table is all strongly not taken and both counters
  // are zero, whatever the address.
  task automatic test_reset_state();
    send_item(bbp_pkg::KIND_LOOKUP, 32'h0000_0000, 1'b1, 0);
    send_item(bbp_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, 0);
    send_item(bbp_pkg::KIND_LOOKUP, 32'h0000_0ABC, 1'b1, 2);
  endtask

  // Walks one entry through all eight transitions. A lookup in the middle
  // carries a not-taken outcome that has to leave the entry alone.
  task automatic test_transitions();
    logic [bbp_pkg::PC_W-1:0] pc;
    pc = 32'h0000_1234;
    send_item(bbp_pkg::KIND_UPDATE, pc, 1'b1, 0);   // strong NT -> weak NT
    send_item(bbp_pkg::KIND_UPDATE, pc, 1'b1, 0);   // weak NT -> strong T
    send_item(bbp_pkg::KIND_LOOKUP, pc, 1'b0, 1);
    send_item(bbp_pkg::KIND_UPDATE, pc, 1'b0, 0);   // strong T -> weak T
    send_item(bbp_pkg::KIND_UPDATE, pc, 1'b1, 3);   // weak T -> strong T
    send_item(bbp_pkg::KIND_UPDATE, pc, 1'b1, 0);   // strong T stays
    send_item(bbp_pkg::KIND_UPDATE, pc, 1'b0, 0);   // strong T -> weak T
    send_item(bbp_pkg::KIND_UPDATE, pc, 1'b0, 0);   // weak T -> strong NT
    send_item(bbp_pkg::KIND_UPDATE, pc, 1'b0, 0);   // strong NT stays
    send_item(bbp_pkg::KIND_UPDATE, pc, 1'b1, 0);   // strong NT -> weak NT
    send_item(bbp_pkg::KIND_UPDATE, pc, 1'b0, 2);   // weak NT -> strong NT
    send_item(bbp_pkg::KIND_LOOKUP, pc, 1'b1, 0);
  endtask

  // A zero width makes every branch share one entry; a width beyond the
  // table folds back onto it. Changing the width leaves the table as it is.
  task automatic test_index_width();
    write_index_bits(4'd0);
    send_item(bbp_pkg::KIND_UPDATE, 32'h0000_0004, 1'b1, 0);
    send_item(bbp_pkg::KIND_UPDATE, 32'h7654_3210, 1'b1, 0);
    send_item(bbp_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, 0);
    write_index_bits(4'd15);
    send_item(bbp_pkg::KIND_UPDATE, 32'h8000_0004, 1'b1, 0);
    send_item(bbp_pkg::KIND_LOOKUP, 32'h0000_1004, 1'b0, 0);
    write_index_bits(bbp_pkg::INDEX_BITS_RST);
    send_item(bbp_pkg::KIND_LOOKUP, 32'h0000_0004, 1'b1, 0);
  endtask

  // Random traffic under a series of widths. Most items hit a few hot
  // branches with a biased outcome, so entries settle into strong states and
  // get knocked out again; the rest are random addresses.
  task automatic test_random_traffic();
    logic [bbp_pkg::CFG_W-1:0] widths [8];
    logic [bbp_pkg::PC_W-1:0]  hot_pc [HOT_PCS];
    int unsigned               bias [HOT_PCS];
    int unsigned               k;
    int unsigned               n;
    int unsigned               gap;
    logic                      kind;
    logic [bbp_pkg::PC_W-1:0]  pc;
    logic                      outcome;
    widths = '{4'd10, 4'd0, 4'd15, 4'd1, 4'd4, 4'd12, 4'd2, 4'd10};
    widths[5] = bbp_pkg::CFG_W'($urandom_range(0, 15));
    for (int phase = 0; phase < 8; phase++) begin
      write_index_bits(widths[phase]);
      for (int h = 0; h < HOT_PCS; h++) begin
        hot_pc[h] = $urandom;
        case ($urandom_range(0, 2))
          0: bias[h] = 10;
          1: bias[h] = 90;
          default: bias[h] = 50;
        endcase
      end
      for (n = 0; n < 190; n++) begin
        if ($urandom_range(0, 99) < 75) begin
          k       = $urandom_range(0, HOT_PCS - 1);
          pc      = hot_pc[k];
          outcome = ($urandom_range(0, 99) < bias[k]);
        end else begin
          pc      = $urandom;
          outcome = 1'($urandom);
        end
        kind = ($urandom_range(0, 99) < 80) ? bbp_pkg::KIND_UPDATE : bbp_pkg::KIND_LOOKUP;
        // Phase three runs with no idle gaps between items, but for an occasional drain.
        gap = (phase == 3) ? 0 : pick_gap();
        send_item(kind, pc, outcome, gap);
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end
  endtask

  // Result checker: a strobe is taken at the edge that closes its cycle.
  always @(posedge clk) begin
    branch_result_t exp_res;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: prediction %0d access %0d mispredict %0d",
               out_prediction, out_access_count, out_mispredict_count);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_prediction !== exp_res.prediction) begin
          $error("prediction: expected %0d, got %0d",
                 exp_res.prediction, out_prediction);
          error_count++;
        end
        if (out_access_count !== exp_res.access_count) begin
          $error("access_count: expected %0d, got %0d",
                 exp_res.access_count, out_access_count);
          error_count++;
        end
        if (out_mispredict_count !== exp_res.mispredict_count) begin
          $error("mispredict_count: expected %0d, got %0d",
                 exp_res.mispredict_count, out_mispredict_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_kind        = bbp_pkg::KIND_LOOKUP;
    in_pc          = '0;
    in_outcome     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index_bits = '0;
    error_count    = 0;
    cycle_count    = 0;
    shadow_updates = '0;
    shadow_wrong   = '0;
    shadow_width   = bbp_pkg::INDEX_BITS_RST;
    for (int i = 0; i < TABLE_ENTRIES; i++) shadow_dirs[i] = bbp_pkg::DIR_STRONG_NT;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // The clearing pass after reset is covered by waiting on busy.
    test_reset_state();
    test_transitions();
    test_index_width();
    test_random_traffic();

    drain_results();
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bbp_pkg.sv
hw/rtl/bbp_ram.sv
hw/rtl/bbp_index.sv
hw/rtl/bimodal_branch_predictor_unit.sv
tb/tb_top.sv
